// ===== hdl/deq_pkg.sv =====
// Shared types, constants and pointer helpers for the double-ended queue.
`default_nettype none

package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int WORD_WIDTH = 32;

	// bits actually kept per word: the input word is 32 bits wide
	localparam int STORE_W = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;

	localparam int FIELD_W    = 32;
	localparam int ENTRY_W    = 5;
	localparam int OUT_BITS   = 3 * FIELD_W + ENTRY_W + 1 + 1 + 2;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	typedef logic [STORE_W-1:0] word_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [1:0] {
		ACT_INS_LEFT  = 2'd0,
		ACT_INS_RIGHT = 2'd1,
		ACT_REM_LEFT  = 2'd2,
		ACT_REM_RIGHT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2
	} err_t;

	// storage port requests from the controller
	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		word_t wdata;
		logic  re;
		ptr_t  raddr;
	} ram_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] removed;
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] right;
		logic [ENTRY_W-1:0] count;
		logic               full;
		logic               empty;
		err_t               err;
	} res_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + PTR_W'(1));
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(p - PTR_W'(1));
	endfunction

	// p + c modulo DEPTH, with c below DEPTH
	function automatic ptr_t ptr_add(input ptr_t p, input cnt_t c);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(p) + SUM_W'(c);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return PTR_W'(sum);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: store, controller and output register.
`default_nettype none

// Double-ended queue of up to DEPTH words. Each input transaction carries one
// operation in s_tuser (insert left, insert right, remove left, remove right)
// and the word to insert in s_tdata; each produces exactly one output
// transaction with the removed word, the leftmost and rightmost words, the
// count, full/empty flags and an error code (overflow on insert when full,
// underflow on remove when empty; a refused operation changes nothing).
// The two end words are cached in registers, so inserts, refused operations
// and removals that leave at most one word need no store read. A removal that
// leaves two or more words waits in ST_READ: the new end word is fetched
// through the store's single registered read port. A result sits in an output
// register; a new transaction is taken while it waits only if it is taken in
// the same cycle. The word store is not cleared at reset and needs no
// initialization pass.
module double_ended_queue_core import deq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // [31:0] item_value
	input  logic [7:0]            s_tuser,  // [1:0] action, [7:2] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] removed_value, [63:32] left_value, [95:64] right_value,
	// [100:96] entry_count, [101] is_full, [102] is_empty, [104:103] error_code
	output logic [OUT_DATA_W-1:0] m_tdata
);

	ram_req_t ram_req;
	word_t    ram_rdata;
	logic     res_valid;
	res_t     res;
	res_t     out_q;
	logic     m_tvalid_q;
	logic     out_free;

	assign out_free = !m_tvalid_q || m_tready;

	deq_ram #(
		.WIDTH(STORE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_action(s_tuser[1:0]),
		.in_value (s_tdata),
		.out_free (out_free),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_q.err, out_q.empty, out_q.full, out_q.count,
		out_q.right, out_q.left, out_q.removed};

endmodule

`default_nettype wire

// ===== hdl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/deq_ctrl.sv =====
// Deque controller: head pointer, count, cached end words and store access sequencing.
`default_nettype none

module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [1:0]  in_action,
	input  logic [31:0] in_value,
	input  logic     out_free,
	output ram_req_t ram_req,
	input  word_t    ram_rdata,
	output logic     res_valid,
	output res_t     res
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t  state_q, state_d;
	ptr_t    head_q, head_d;
	cnt_t    cnt_q, cnt_d;
	word_t   left_q, left_d;
	word_t   right_q, right_d;
	res_t    pend_q, pend_d;
	logic    pend_left_q, pend_left_d;

	action_t act;
	word_t   val;
	word_t   removed;
	err_t    err;
	logic    need_read;
	logic    is_full_now;
	logic    is_empty_now;
	logic    fire;
	res_t    res_now;

	assign act          = action_t'(in_action);
	assign val          = STORE_W'(in_value);
	assign in_ready     = (state_q == ST_IDLE) && out_free;
	assign fire         = in_valid && in_ready;
	assign is_full_now  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty_now = (cnt_q == '0);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		cnt_d       = cnt_q;
		left_d      = left_q;
		right_d     = right_q;
		pend_d      = pend_q;
		pend_left_d = pend_left_q;
		ram_req     = '0;
		removed     = '0;
		err         = ERR_OK;
		need_read   = 1'b0;
		res_valid   = 1'b0;
		res         = pend_q;
		res_now     = pend_q;

		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					case (act)
						ACT_INS_LEFT: begin
							if (is_full_now) begin
								err = ERR_OVERFLOW;
							end else begin
								head_d        = ptr_dec(head_q);
								ram_req.we    = 1'b1;
								ram_req.waddr = head_d;
								ram_req.wdata = val;
								cnt_d         = cnt_q + CNT_W'(1);
								left_d        = val;
								if (is_empty_now) begin
									right_d = val;
								end
							end
						end
						ACT_INS_RIGHT: begin
							if (is_full_now) begin
								err = ERR_OVERFLOW;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.waddr = ptr_add(head_q, cnt_q);
								ram_req.wdata = val;
								cnt_d         = cnt_q + CNT_W'(1);
								right_d       = val;
								if (is_empty_now) begin
									left_d = val;
								end
							end
						end
						ACT_REM_LEFT: begin
							if (is_empty_now) begin
								err = ERR_UNDERFLOW;
							end else begin
								removed = left_q;
								head_d  = ptr_inc(head_q);
								cnt_d   = cnt_q - CNT_W'(1);
								if (cnt_q == CNT_W'(1)) begin
									left_d  = '0;
									right_d = '0;
								end else if (cnt_q == CNT_W'(2)) begin
									left_d = right_q;
								end else begin
									// new leftmost word comes from the store
									need_read     = 1'b1;
									ram_req.re    = 1'b1;
									ram_req.raddr = head_d;
									pend_left_d   = 1'b1;
								end
							end
						end
						ACT_REM_RIGHT: begin
							if (is_empty_now) begin
								err = ERR_UNDERFLOW;
							end else begin
								removed = right_q;
								cnt_d   = cnt_q - CNT_W'(1);
								if (cnt_q == CNT_W'(1)) begin
									left_d  = '0;
									right_d = '0;
								end else if (cnt_q == CNT_W'(2)) begin
									right_d = left_q;
								end else begin
									need_read     = 1'b1;
									ram_req.re    = 1'b1;
									ram_req.raddr = ptr_add(head_q, cnt_q - CNT_W'(2));
									pend_left_d   = 1'b0;
								end
							end
						end
						default: begin
						end
					endcase

					res_now.removed = FIELD_W'(removed);
					res_now.left    = FIELD_W'(left_d);
					res_now.right   = FIELD_W'(right_d);
					res_now.count   = ENTRY_W'(cnt_d);
					res_now.full    = (cnt_d == CNT_W'(DEPTH));
					res_now.empty   = (cnt_d == '0);
					res_now.err     = err;

					if (need_read) begin
						pend_d  = res_now;
						state_d = ST_READ;
					end else begin
						res_valid = 1'b1;
						res       = res_now;
					end
				end
			end
			ST_READ: begin
				res_valid = 1'b1;
				if (pend_left_q) begin
					left_d   = ram_rdata;
					res.left = FIELD_W'(ram_rdata);
				end else begin
					right_d   = ram_rdata;
					res.right = FIELD_W'(ram_rdata);
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q      <= pend_d;
		pend_left_q <= pend_left_d;
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("held count above capacity");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_IDLE)
		else $error("store read wait longer than one cycle");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("store written and read in the same cycle");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> (left_q == '0 && right_q == '0))
		else $error("cached end words not cleared while empty");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> res_valid && !in_ready)
		else $error("read completion without result");
`endif

endmodule

`default_nettype wire
